// ===== rtl/assert_macros.svh =====
// assertion macros shared by the encoder pid blocks
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EPW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");
`define EPW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition: %m");
`else
`define EPW_ASSERT(lbl, clk, rst_n, prop)
`define EPW_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/epw_pkg.sv =====
// types, widths and constants for the encoder pid pulse width block
// no dependencies; imported by every module of the block
`default_nettype none
package epw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int GAIN_W     = 16;
  localparam int PULSE_W    = 22;
  localparam int STEP_W     = 10;
  localparam int TICK_W     = 16;
  localparam int SP_W       = 16;
  localparam int POS_W      = 32;
  localparam int ANG_W      = 48;
  localparam int Q_FRAC     = 16;
  localparam int KQ_W       = 24;
  localparam int KQ_FRAC    = 8;
  localparam int MUL_A_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + KQ_W;
  localparam int ACC_W      = ANG_W + KQ_W;
  localparam int TERM_W     = 61;
  localparam int SUM_W      = 63;
  localparam int UMAG_W     = SUM_W - 1 - Q_FRAC;
  localparam int PW_W       = 48;

  localparam logic [KQ_W-1:0]   DEG_PER_COUNT_Q24 = 24'd145354;
  localparam logic [ANG_W-1:0]  MAX48    = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic [ANG_W-1:0]  MIN48    = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, {(TERM_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP      = 16'd2000;
  localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG     = 16'd10;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV     = 16'd50;
  localparam logic [PULSE_W-1:0] RST_PULSE_CENTER   = 22'd1460000;
  localparam logic [PULSE_W-1:0] RST_PULSE_MIN      = 22'd1000000;
  localparam logic [PULSE_W-1:0] RST_PULSE_MAX      = 22'd2000000;
  localparam logic [STEP_W-1:0]  RST_SETPOINT_STEP  = 10'd45;
  localparam logic [TICK_W-1:0]  RST_TICKS_PER_STEP = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP,
    CFG_GAIN_INTEG,
    CFG_GAIN_DERIV,
    CFG_PULSE_CENTER,
    CFG_PULSE_MIN,
    CFG_PULSE_MAX,
    CFG_SETPOINT_STEP,
    CFG_TICKS_PER_STEP
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_prop;
    logic [GAIN_W-1:0]  gain_integ;
    logic [GAIN_W-1:0]  gain_deriv;
    logic [PULSE_W-1:0] pulse_center;
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    logic [STEP_W-1:0]  setpoint_step;
    logic [TICK_W-1:0]  ticks_per_step;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    position_valid;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_W-1:0]      pulse_width;
    logic signed [ANG_W-1:0] angle;
    logic signed [ANG_W-1:0] error;
    logic                    clamped;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CMAG,
    ST_ANG_LO,
    ST_ANG_HI,
    ST_ANG_FIN,
    ST_ERR,
    ST_ERR2,
    ST_MAG,
    ST_P_LO,
    ST_P_HI,
    ST_I_LO,
    ST_I_HI,
    ST_D_LO,
    ST_D_HI,
    ST_SUM_D,
    ST_PULSE1,
    ST_PULSE2,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_ANG,
    SEL_P,
    SEL_I,
    SEL_D
  } op_sel_t;

  typedef struct packed {
    logic    accept;
    logic    cmag;
    logic    mul_en;
    logic    mul_hi;
    op_sel_t mul_sel;
    logic    term_add;
    logic    ang_fin;
    logic    err;
    logic    err2;
    logic    mag;
    logic    pulse1;
    logic    pulse2;
    logic    out_load;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/epw_regs.sv =====
// configuration register file: gains, pulse limits and setpoint staircase
// depends on epw_pkg
`default_nettype none
module epw_regs import epw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop      <= RST_GAIN_PROP;
      cfg_r.gain_integ     <= RST_GAIN_INTEG;
      cfg_r.gain_deriv     <= RST_GAIN_DERIV;
      cfg_r.pulse_center   <= RST_PULSE_CENTER;
      cfg_r.pulse_min      <= RST_PULSE_MIN;
      cfg_r.pulse_max      <= RST_PULSE_MAX;
      cfg_r.setpoint_step  <= RST_SETPOINT_STEP;
      cfg_r.ticks_per_step <= RST_TICKS_PER_STEP;
    end else if (cfg_we) begin
      // data wider than a register is cut to its width
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN_PROP:      cfg_r.gain_prop      <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_INTEG:     cfg_r.gain_integ     <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_DERIV:     cfg_r.gain_deriv     <= cfg_wdata[GAIN_W-1:0];
        CFG_PULSE_CENTER:   cfg_r.pulse_center   <= cfg_wdata[PULSE_W-1:0];
        CFG_PULSE_MIN:      cfg_r.pulse_min      <= cfg_wdata[PULSE_W-1:0];
        CFG_PULSE_MAX:      cfg_r.pulse_max      <= cfg_wdata[PULSE_W-1:0];
        CFG_SETPOINT_STEP:  cfg_r.setpoint_step  <= cfg_wdata[STEP_W-1:0];
        CFG_TICKS_PER_STEP: cfg_r.ticks_per_step <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== rtl/epw_ctrl.sv =====
// sequencer for one control tick: steps the datapath through scaling,
// error update, three gain products and the pulse clamp; depends on epw_pkg
`default_nettype none
`include "assert_macros.svh"
module epw_ctrl import epw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_free,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_CMAG;
      ST_CMAG:    state_nxt = ST_ANG_LO;
      ST_ANG_LO:  state_nxt = ST_ANG_HI;
      ST_ANG_HI:  state_nxt = ST_ANG_FIN;
      ST_ANG_FIN: state_nxt = ST_ERR;
      ST_ERR:     state_nxt = ST_ERR2;
      ST_ERR2:    state_nxt = ST_MAG;
      ST_MAG:     state_nxt = ST_P_LO;
      ST_P_LO:    state_nxt = ST_P_HI;
      ST_P_HI:    state_nxt = ST_I_LO;
      ST_I_LO:    state_nxt = ST_I_HI;
      ST_I_HI:    state_nxt = ST_D_LO;
      ST_D_LO:    state_nxt = ST_D_HI;
      ST_D_HI:    state_nxt = ST_SUM_D;
      ST_SUM_D:   state_nxt = ST_PULSE1;
      ST_PULSE1:  state_nxt = ST_PULSE2;
      ST_PULSE2:  state_nxt = ST_DONE;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = SEL_ANG;
    unique case (state_r)
      ST_IDLE:    cmd.accept = in_valid;
      ST_CMAG:    cmd.cmag = 1'b1;
      ST_ANG_LO:  cmd.mul_en = 1'b1;
      ST_ANG_HI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
      end
      ST_ANG_FIN: cmd.ang_fin = 1'b1;
      ST_ERR:     cmd.err = 1'b1;
      ST_ERR2:    cmd.err2 = 1'b1;
      ST_MAG:     cmd.mag = 1'b1;
      ST_P_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_P;
      end
      ST_P_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = SEL_P;
      end
      // previous term is folded into the sum while the next low half multiplies
      ST_I_LO: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = SEL_I;
        cmd.term_add = 1'b1;
      end
      ST_I_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = SEL_I;
      end
      ST_D_LO: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = SEL_D;
        cmd.term_add = 1'b1;
      end
      ST_D_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_hi  = 1'b1;
        cmd.mul_sel = SEL_D;
      end
      ST_SUM_D:   cmd.term_add = 1'b1;
      ST_PULSE1:  cmd.pulse1 = 1'b1;
      ST_PULSE2:  cmd.pulse2 = 1'b1;
      ST_DONE:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  `EPW_ASSERT(a_accept_starts_tick, clk, rst_n, (in_valid && !in_stall) |=> (state_r == ST_CMAG))
  `EPW_ASSERT(a_done_returns, clk, rst_n, (state_r == ST_DONE && out_free) |=> (state_r == ST_IDLE))
  `EPW_ASSERT_NEVER(a_mul_outside_tick, clk, rst_n, cmd.mul_en && (state_r == ST_IDLE || state_r == ST_DONE))

endmodule
`default_nettype wire

// ===== rtl/epw_dp.sv =====
// datapath: count tracking, shared 32x24 multiplier with accumulator,
// error and pid state, pulse clamp and output register; depends on epw_pkg
`default_nettype none
`include "assert_macros.svh"
module epw_dp import epw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output logic      out_free,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(3) <<< (TERM_W - 1);

  function automatic logic [ANG_W-1:0] sat48(input logic [ANG_W:0] v);
    if (v[ANG_W] != v[ANG_W-1]) begin
      return v[ANG_W] ? MIN48 : MAX48;
    end
    return v[ANG_W-1:0];
  endfunction

  // encoder tracking and pid state
  logic [POS_W-1:0]        prev_count_r;
  logic                    primed_r;
  logic signed [ANG_W-1:0] count_total_r;
  logic [TICK_W-1:0]       tick_r;
  logic [SP_W-1:0]         sp_r;
  logic signed [ANG_W-1:0] error_prev_r;
  logic signed [ANG_W-1:0] error_sum_r;

  // per-tick working registers
  logic [ANG_W-1:0]        cmag_r;
  logic                    cneg_r;
  logic [ACC_W-1:0]        acc_r;
  logic                    term_neg_r;
  logic signed [ANG_W-1:0] angle_r;
  logic signed [ANG_W-1:0] error_r;
  logic signed [ANG_W:0]   diff_r;
  logic [ANG_W-1:0]        pmag_r, imag_r, dmag_r;
  logic                    pneg_r, ineg_r, dneg_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [UMAG_W-1:0]       umag_r;
  logic                    uneg_r;
  logic signed [PW_W-1:0]  pw_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [POS_W-1:0]        prev_eff, delta;
  logic [ANG_W-1:0]        count_next;
  logic [ANG_W-1:0]        op_mag;
  logic                    op_neg;
  logic [GAIN_W-1:0]       gain;
  logic [MUL_A_W-1:0]      mul_a;
  logic [KQ_W-1:0]         mul_b;
  logic [MUL_P_W-1:0]      mul_p;
  logic [ACC_W-1:0]        acc_next;
  logic [TERM_W-1:0]       term_sat;
  logic [SUM_W-1:0]        term_ext;
  logic [SUM_W-1:0]        term_s;
  logic [ACC_W-KQ_FRAC-1:0] ang_q;
  logic [ANG_W-1:0]        ang_mag;
  logic [ANG_W:0]          err_wide, diff_wide, esum_wide;
  logic [ANG_W:0]          diff_abs;
  logic [SUM_W-1:0]        sum_abs;
  logic [PW_W-1:0]         center_ext, umag_ext;
  logic [TICK_W:0]         tick_inc;
  logic [SP_W:0]           sp_sum;
  logic signed [PW_W-1:0]  min_ext, max_ext;
  out_item_t               out_next;

  // first valid sample primes the previous count, giving a zero delta
  assign prev_eff   = primed_r ? prev_count_r : in_data.position;
  assign delta      = in_data.position - prev_eff;
  assign count_next = count_total_r + {{(ANG_W-POS_W){delta[POS_W-1]}}, delta};

  always_comb begin
    unique case (cmd.mul_sel)
      SEL_ANG: begin
        op_mag = cmag_r;
        op_neg = cneg_r;
        gain   = '0;
      end
      SEL_P: begin
        op_mag = pmag_r;
        op_neg = pneg_r;
        gain   = cfg.gain_prop;
      end
      SEL_I: begin
        op_mag = imag_r;
        op_neg = ineg_r;
        gain   = cfg.gain_integ;
      end
      SEL_D: begin
        op_mag = dmag_r;
        op_neg = dneg_r;
        gain   = cfg.gain_deriv;
      end
      default: begin
        op_mag = cmag_r;
        op_neg = cneg_r;
        gain   = '0;
      end
    endcase
  end

  // one shared multiplier, operand split in a low and a high half
  assign mul_a = cmd.mul_hi ? MUL_A_W'(op_mag[ANG_W-1:MUL_A_W]) : op_mag[MUL_A_W-1:0];
  assign mul_b = (cmd.mul_sel == SEL_ANG) ? DEG_PER_COUNT_Q24 : KQ_W'(gain);
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign acc_next = cmd.mul_hi ? acc_r + {mul_p[ACC_W-MUL_A_W-1:0], MUL_A_W'(0)}
                               : ACC_W'(mul_p);

  // each gain product is limited in magnitude to 2^60
  assign term_sat = (acc_r > ACC_W'(TERM_LIM)) ? TERM_LIM : acc_r[TERM_W-1:0];
  assign term_ext = SUM_W'(term_sat);
  assign term_s   = term_neg_r ? -term_ext : term_ext;

  assign ang_q   = acc_r[ACC_W-1:KQ_FRAC];
  assign ang_mag = (ang_q > (ACC_W-KQ_FRAC)'(MAX48)) ? MAX48 : ang_q[ANG_W-1:0];

  assign err_wide  = {{(ANG_W+1-SP_W-Q_FRAC){1'b0}}, sp_r, Q_FRAC'(0)}
                   - {angle_r[ANG_W-1], angle_r};
  assign diff_wide = {error_r[ANG_W-1], error_r} - {error_prev_r[ANG_W-1], error_prev_r};
  assign esum_wide = {error_sum_r[ANG_W-1], error_sum_r} + {error_r[ANG_W-1], error_r};
  assign diff_abs  = diff_r[ANG_W] ? -diff_r : diff_r;

  assign sum_abs    = sum_r[SUM_W-1] ? -sum_r : sum_r;
  assign center_ext = PW_W'(cfg.pulse_center);
  assign umag_ext   = PW_W'(umag_r);

  assign tick_inc = {1'b0, tick_r} + (TICK_W+1)'(1);
  assign sp_sum   = {1'b0, sp_r} + (SP_W+1)'(cfg.setpoint_step);

  assign min_ext = $signed(PW_W'(cfg.pulse_min));
  assign max_ext = $signed(PW_W'(cfg.pulse_max));

  // minimum is tested first, so it wins when the limits cross
  always_comb begin
    out_next.angle = angle_r;
    out_next.error = error_r;
    priority if (pw_r < min_ext) begin
      out_next.pulse_width = cfg.pulse_min;
      out_next.clamped     = 1'b1;
    end else if (pw_r > max_ext) begin
      out_next.pulse_width = cfg.pulse_max;
      out_next.clamped     = 1'b1;
    end else begin
      out_next.pulse_width = pw_r[PULSE_W-1:0];
      out_next.clamped     = 1'b0;
    end
  end

  // state that persists across ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r  <= '0;
      primed_r      <= 1'b0;
      count_total_r <= '0;
      tick_r        <= '0;
      sp_r          <= '0;
      error_prev_r  <= '0;
      error_sum_r   <= '0;
    end else begin
      if (cmd.accept && in_data.position_valid) begin
        prev_count_r  <= in_data.position;
        primed_r      <= 1'b1;
        count_total_r <= $signed(count_next);
      end
      if (cmd.err2) begin
        error_prev_r <= error_r;
        error_sum_r  <= $signed(sat48(esum_wide));
        if (tick_inc >= {1'b0, cfg.ticks_per_step}) begin
          tick_r <= '0;
          sp_r   <= sp_sum[SP_W] ? '1 : sp_sum[SP_W-1:0];
        end else begin
          tick_r <= tick_inc[TICK_W-1:0];
        end
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.cmag) begin
      cmag_r <= count_total_r[ANG_W-1] ? -count_total_r : count_total_r;
      cneg_r <= count_total_r[ANG_W-1];
    end
    if (cmd.mul_en) begin
      acc_r <= acc_next;
    end
    if (cmd.mul_en && cmd.mul_hi) begin
      term_neg_r <= op_neg;
    end
    if (cmd.ang_fin) begin
      angle_r <= cneg_r ? $signed(-ang_mag) : $signed(ang_mag);
    end
    if (cmd.err) begin
      error_r <= $signed(sat48(err_wide));
    end
    if (cmd.err2) begin
      diff_r <= $signed(diff_wide);
    end
    if (cmd.mag) begin
      pmag_r <= error_r[ANG_W-1] ? -error_r : error_r;
      pneg_r <= error_r[ANG_W-1];
      imag_r <= error_sum_r[ANG_W-1] ? -error_sum_r : error_sum_r;
      ineg_r <= error_sum_r[ANG_W-1];
      dmag_r <= diff_abs[ANG_W-1:0];
      dneg_r <= diff_r[ANG_W];
      sum_r  <= '0;
    end else if (cmd.term_add) begin
      sum_r <= sum_r + $signed(term_s);
    end
    if (cmd.pulse1) begin
      umag_r <= sum_abs[SUM_W-2:Q_FRAC];
      uneg_r <= sum_r[SUM_W-1];
    end
    if (cmd.pulse2) begin
      pw_r <= uneg_r ? $signed(center_ext - umag_ext) : $signed(center_ext + umag_ext);
    end
    if (cmd.out_load) begin
      out_data_r <= out_next;
    end
  end

  // output register: a finished result waits here until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `EPW_ASSERT(a_angle_magnitude, clk, rst_n, out_valid_r |-> (out_data_r.angle != MIN48))
  `EPW_ASSERT(a_clamp_at_limit, clk, rst_n, (out_valid_r && out_data_r.clamped) |-> (out_data_r.pulse_width == cfg.pulse_min || out_data_r.pulse_width == cfg.pulse_max))
  `EPW_ASSERT(a_sum_in_range, clk, rst_n, cmd.pulse1 |-> (sum_r <= SUM_LIM && sum_r >= -SUM_LIM))

endmodule
`default_nettype wire

// ===== rtl/encoder_pid_pulse_width.sv =====
// One control tick per input transfer: the encoder count is tracked into a Q16
// angle, the error to a staircase setpoint runs through a PID with saturating
// sum, and the result is a clamped pulse width. Ticks are paced by the shared
// single 32x24 multiplier, two passes each for the angle scaling and the three
// gain products; a new tick is taken only in idle. The result sits in an output
// register; the next tick is taken while it waits, and only the final step holds
// if not yet transferred. The user must write configuration through the plain
// write port only while idle; the block itself does not enforce this.
// depends on epw_pkg, epw_regs, epw_ctrl and epw_dp
`default_nettype none
module encoder_pid_pulse_width import epw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;
  logic out_free;

  epw_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  epw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .cmd      (cmd)
  );

  epw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_free  (out_free),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== test/encoder_pid_pulse_width_test.sv =====
// self-checking testbench for encoder_pid_pulse_width: predicts every control tick in
// a scoreboard class, drives the input channel and register port with tasks and
// out_stall from its own process; depends on epw_pkg and the encoder_pid_pulse_width rtl
`timescale 1ns / 1ps
module encoder_pid_pulse_width_test import epw_pkg::*; ();

  localparam int     CYCLE_LIMIT = 600000;
  localparam longint ANG_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ANG_MIN     = -ANG_MAX - 1;
  localparam longint unsigned TERM_CAP = 64'd1 << 60;
  localparam longint unsigned K_INT  = 64'(DEG_PER_COUNT_Q24) >> KQ_FRAC;
  localparam longint unsigned K_FRAC = 64'(DEG_PER_COUNT_Q24) & ((64'd1 << KQ_FRAC) - 1);

  typedef enum int {SEG_WALK, SEG_JUMP, SEG_SLEW_UP, SEG_SLEW_DOWN} seg_t;
  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_BURSTS} flow_t;

  class pulse_scoreboard;
    logic [GAIN_W-1:0]  kp, ki, kd;
    logic [PULSE_W-1:0] center, pmin, pmax;
    logic [STEP_W-1:0]  sp_step;
    logic [TICK_W-1:0]  tps;

    int          prev_count;
    bit          primed;
    longint      count_total;
    int unsigned tick_cnt;
    int unsigned setpoint;
    longint      err_prev;
    longint      err_sum;

    out_item_t pending_pulses[$];
    int n_checked;
    int n_clamped;
    int n_fail;

    function new();
      kp = RST_GAIN_PROP;
      ki = RST_GAIN_INTEG;
      kd = RST_GAIN_DERIV;
      center = RST_PULSE_CENTER;
      pmin = RST_PULSE_MIN;
      pmax = RST_PULSE_MAX;
      sp_step = RST_SETPOINT_STEP;
      tps = RST_TICKS_PER_STEP;
      prev_count = 0;
      primed = 1'b0;
      count_total = 0;
      tick_cnt = 0;
      setpoint = 0;
      err_prev = 0;
      err_sum = 0;
      n_checked = 0;
      n_clamped = 0;
      n_fail = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_PROP:      kp = data[GAIN_W-1:0];
        CFG_GAIN_INTEG:     ki = data[GAIN_W-1:0];
        CFG_GAIN_DERIV:     kd = data[GAIN_W-1:0];
        CFG_PULSE_CENTER:   center = data[PULSE_W-1:0];
        CFG_PULSE_MIN:      pmin = data[PULSE_W-1:0];
        CFG_PULSE_MAX:      pmax = data[PULSE_W-1:0];
        CFG_SETPOINT_STEP:  sp_step = data[STEP_W-1:0];
        CFG_TICKS_PER_STEP: tps = data[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint sat48(longint v);
      if (v > ANG_MAX) return ANG_MAX;
      if (v < ANG_MIN) return ANG_MIN;
      return v;
    endfunction

    function longint gain_product(logic [GAIN_W-1:0] g, longint x);
      longint unsigned m, p;
      m = magnitude(x);
      if (g != 0 && m > TERM_CAP / g) p = TERM_CAP;
      else p = m * g;
      return (x < 0) ? -longint'(p) : longint'(p);
    endfunction

    // one control tick: count tracking, angle, pid, clamp, then the stair setpoint
    function void note_tick(in_item_t it);
      int                      d;
      logic signed [ANG_W-1:0] wrapped;
      longint unsigned         m, q, mag;
      longint                  angle, err, diff, sum, u, pw;
      bit                      clamp;
      out_item_t               want;
      if (it.position_valid) begin
        if (!primed) begin
          prev_count = it.position;
          primed = 1'b1;
        end
        d = it.position - prev_count;
        prev_count = it.position;
        wrapped = ANG_W'(count_total + longint'(d));
        count_total = longint'(wrapped);
      end
      m = magnitude(count_total);
      q = m * K_INT + ((m * K_FRAC) >> KQ_FRAC);
      if (q > ANG_MAX) q = ANG_MAX;
      angle = (count_total < 0) ? -longint'(q) : longint'(q);

      err = sat48((longint'(setpoint) << Q_FRAC) - angle);
      diff = err - err_prev;
      err_prev = err;
      err_sum = sat48(err_sum + err);

      sum = gain_product(kp, err) + gain_product(kd, diff) + gain_product(ki, err_sum);
      mag = magnitude(sum) >> Q_FRAC;
      u = (sum < 0) ? -longint'(mag) : longint'(mag);

      pw = longint'(center) + u;
      clamp = 1'b0;
      // the lower bound wins the test when min sits above max
      if (pw < longint'(pmin)) begin
        pw = longint'(pmin);
        clamp = 1'b1;
      end else if (pw > longint'(pmax)) begin
        pw = longint'(pmax);
        clamp = 1'b1;
      end

      if (tick_cnt + 1 >= tps) begin
        tick_cnt = 0;
        setpoint = setpoint + sp_step;
        if (setpoint > 65535) setpoint = 65535;
      end else begin
        tick_cnt++;
      end

      want.pulse_width = pw[PULSE_W-1:0];
      want.angle = angle[ANG_W-1:0];
      want.error = err[ANG_W-1:0];
      want.clamped = clamp;
      if (clamp) n_clamped++;
      pending_pulses.push_back(want);
    endfunction

    function void check_pulse(out_item_t got);
      out_item_t want;
      if (pending_pulses.size() == 0) begin
        $error("result with no tick waiting: pulse_width %0d", got.pulse_width);
        n_fail++;
        return;
      end
      want = pending_pulses.pop_front();
      n_checked++;
      if (got.pulse_width !== want.pulse_width) begin
        $error("pulse_width: expected %0d, got %0d", want.pulse_width, got.pulse_width);
        n_fail++;
      end
      if (got.angle !== want.angle) begin
        $error("angle: expected %0d, got %0d", want.angle, got.angle);
        n_fail++;
      end
      if (got.error !== want.error) begin
        $error("error: expected %0d, got %0d", want.error, got.error);
        n_fail++;
      end
      if (got.clamped !== want.clamped) begin
        $error("clamped: expected %0b, got %0b", want.clamped, got.clamped);
        n_fail++;
      end
    endfunction

    function int pending_count();
      return pending_pulses.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pulse_scoreboard sb;
  int              shaft;
  int              n_settings;
  int              cycle_count = 0;

  encoder_pid_pulse_width u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_tick(in_data);
      if (out_valid && !out_stall) sb.check_pulse(out_data);
    end
  end

  // receiver back-pressure, independent of the sender
  initial begin : stall_pattern
    flow_t flow;
    int    run;
    out_stall = 1'b0;
    forever begin
      flow = flow_t'($urandom_range(0, 3));
      for (int k = 0; k < 8; k++) begin
        if (flow == FLOW_BURSTS) begin
          run = $urandom_range(1, 40);
          repeat (run) begin
            @(negedge clk);
            out_stall = 1'b1;
          end
          run = $urandom_range(1, 20);
          repeat (run) begin
            @(negedge clk);
            out_stall = 1'b0;
          end
        end else begin
          repeat (20) begin
            @(negedge clk);
            case (flow)
              FLOW_LIGHT: out_stall = ($urandom_range(0, 99) < 25);
              FLOW_HEAVY: out_stall = ($urandom_range(0, 99) < 60);
              default:    out_stall = 1'b0;
            endcase
          end
        end
      end
    end
  end

  task automatic send_tick(input logic [POS_W-1:0] pos, input logic valid);
    @(negedge clk);
    in_valid = 1'b1;
    in_data.position = pos;
    in_data.position_valid = valid;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] data;
    // junk above the register width must be dropped by the block
    data = CFG_DATA_W'($urandom);
    case (idx)
      CFG_PULSE_CENTER, CFG_PULSE_MIN, CFG_PULSE_MAX: data = CFG_DATA_W'(val);
      CFG_SETPOINT_STEP: data[STEP_W-1:0] = STEP_W'(val);
      default: data[GAIN_W-1:0] = GAIN_W'(val);
    endcase
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(input int unsigned kp, input int unsigned ki,
                                input int unsigned kd, input int unsigned center,
                                input int unsigned pmin, input int unsigned pmax,
                                input int unsigned step, input int unsigned tps);
    wait_for_results();
    write_reg(CFG_GAIN_PROP, kp);
    write_reg(CFG_GAIN_INTEG, ki);
    write_reg(CFG_GAIN_DERIV, kd);
    write_reg(CFG_PULSE_CENTER, center);
    write_reg(CFG_PULSE_MIN, pmin);
    write_reg(CFG_PULSE_MAX, pmax);
    write_reg(CFG_SETPOINT_STEP, step);
    write_reg(CFG_TICKS_PER_STEP, tps);
    n_settings++;
  endtask

  // bursts of ticks with random gaps; the shaft moves in segments of one kind of motion
  task automatic run_ticks(input int n);
    int               burst_left, gap, seg_left;
    seg_t             seg;
    logic [POS_W-1:0] pos;
    logic             valid;
    burst_left = 0;
    seg_left = 0;
    seg = SEG_WALK;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
        repeat (gap) begin
          @(negedge clk);
          in_valid = 1'b0;
        end
      end
      if (seg_left == 0) begin
        seg = seg_t'($urandom_range(0, 3));
        seg_left = $urandom_range(5, 60);
      end
      valid = ($urandom_range(0, 9) != 0);
      if (!valid) begin
        pos = $urandom;
      end else begin
        case (seg)
          SEG_WALK:    shaft = shaft + int'($urandom_range(0, 4000)) - 2000;
          SEG_JUMP:    shaft = $urandom;
          SEG_SLEW_UP: shaft = shaft + 32'h7FFF_FFFF - $urandom_range(0, 255);
          default:     shaft = shaft + 32'h8000_0000 + $urandom_range(0, 255);
        endcase
        pos = shaft;
      end
      send_tick(pos, valid);
      burst_left--;
      seg_left--;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    int unsigned center, pmin, pmax;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_GAIN_PROP;
    cfg_wdata = '0;
    shaft = 0;
    n_settings = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: held count before priming, priming, encoder wrap both ways
    send_tick(32'h0000_0000, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b0);
    send_tick(32'h7FFF_FFFF, 1'b1);
    send_tick(32'h8000_0000, 1'b1);
    send_tick(32'h7FFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 1'b1);
    send_tick(32'h8000_0000, 1'b1);
    send_tick(32'h5555_5555, 1'b0);
    send_tick(32'hAAAA_AAAA, 1'b0);
    shaft = 32'h8000_0000;
    repeat (7) begin
      shaft = shaft + 32'h7FFF_FFFF;
      send_tick(shaft, 1'b1);
    end
    repeat (4) begin
      shaft = shaft + 32'h8000_0001;
      send_tick(shaft, 1'b1);
    end
    send_tick(shaft + 1, 1'b1);
    send_tick(shaft, 1'b1);
    @(negedge clk);
    in_valid = 1'b0;

    for (int p = 0; p < 7; p++) begin
      center = $urandom_range(1000000, 1900000);
      pmin = center - $urandom_range(0, 600000);
      pmax = center + $urandom_range(0, 600000);
      apply_settings(($urandom_range(0, 1) != 0) ? $urandom_range(0, 4000)
                                                 : $urandom_range(0, 65535),
                     $urandom_range(0, (p == 3) ? 65535 : 200),
                     $urandom_range(0, 400), center, pmin, pmax,
                     $urandom_range(0, 120),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(1, 150));
      run_ticks(90);
    end

    // long step period, then lowered below the tick count already reached
    apply_settings(2000, 10, 50, 1460000, 1000000, 2000000, 45, 65535);
    run_ticks(60);
    wait_for_results();
    write_reg(CFG_TICKS_PER_STEP, 2);
    n_settings++;
    run_ticks(40);

    // min above max, zero step period
    apply_settings(2000, 0, 50, 1460000, 1500000, 1400000, 3, 0);
    run_ticks(80);

    // no gain: the pulse sits at the centre, at both ends of its range
    apply_settings(0, 0, 0, 0, 0, 4194303, 0, 1);
    run_ticks(30);
    apply_settings(0, 0, 0, 4194303, 0, 4194303, 1, 7);
    run_ticks(30);

    // full gains, steepest staircase to the ceiling, a long slew into angle saturation
    apply_settings(65535, 65535, 65535, 2097152, 0, 4194303, 1023, 1);
    repeat (200) begin
      shaft = shaft + 32'h7FFF_FFFF;
      send_tick(shaft, 1'b1);
    end
    @(negedge clk);
    in_valid = 1'b0;
    run_ticks(40);

    wait_for_results();
    repeat (40) @(posedge clk);
    $display("checked %0d control ticks over %0d register settings, %0d of them clamped",
             sb.n_checked, n_settings, sb.n_clamped);
    if (sb.n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== encoder_pid_pulse_width.f =====
+incdir+rtl
rtl/epw_pkg.sv
rtl/epw_regs.sv
rtl/epw_ctrl.sv
rtl/epw_dp.sv
rtl/encoder_pid_pulse_width.sv
test/encoder_pid_pulse_width_test.sv
